[hw/rtl/mutf8_pkg.sv]
// mutf8_pkg: shared types and constants for the modified utf-8 string decoder
// no dependencies; imported by every module of the block
package mutf8_pkg;

   // decoder phase
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_LEAD   = 3'd2,
      PH_CONT   = 3'd3,
      PH_TERM   = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_UNIT     = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MALFORMED = 2'd1;
   localparam logic [1:0] ERR_LIMIT     = 2'd2;

   // last prefix byte position (fifth byte)
   localparam logic [2:0] PREFIX_LAST_POS = 3'd4;

   // smallest values that need two or three bytes
   localparam logic [15:0] MIN_TWO_BYTE   = 16'h0080;
   localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [31:0] declared_count;
      logic        last;
   } rsp_type;

endpackage

[hw/rtl/mutf8_in_stage.sv]
// mutf8_in_stage: input register holding one accepted byte transfer
// depends on mutf8_pkg
module mutf8_in_stage
   import mutf8_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_ready = !valid_ff || advance;

   // load on transfer, drain when the item moves on
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/mutf8_core.sv]
// mutf8_core: decoder state and per-byte decode logic
// depends on mutf8_pkg
module mutf8_core
   import mutf8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  req_type     item,
   input  logic [31:0] max_units,
   output logic        res_valid,
   output rsp_type     res
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] units_ff, units_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  cont_ff, cont_in;
   logic [1:0]  seq_ff, seq_in;

   // state as seen by this byte, after a possible restart
   phase_type   eff_phase;
   logic [2:0]  eff_pos;
   logic [31:0] eff_acc;
   logic [31:0] eff_units;
   logic [15:0] eff_partial;
   logic [1:0]  eff_cont;
   logic [1:0]  eff_seq;

   logic [7:0]  b;
   logic [31:0] shifted;
   logic [31:0] acc_new;
   logic [31:0] units_dec;
   logic [15:0] part_new;
   logic [1:0]  cont_dec;
   logic        overlong;

   assign b = item.data_byte;

   always_comb begin
      if (item.first_byte) begin
         eff_phase   = PH_PREFIX;
         eff_pos     = '0;
         eff_acc     = '0;
         eff_units   = '0;
         eff_partial = '0;
         eff_cont    = '0;
         eff_seq     = '0;
      end else begin
         eff_phase   = phase_ff;
         eff_pos     = pos_ff;
         eff_acc     = acc_ff;
         eff_units   = units_ff;
         eff_partial = partial_ff;
         eff_cont    = cont_ff;
         eff_seq     = seq_ff;
      end
   end

   // place the payload bits of a prefix byte: seven at positions 0 to 3, four at position 4
   always_comb begin
      case (eff_pos)
         3'd0:    shifted = {25'd0, b[6:0]};
         3'd1:    shifted = {18'd0, b[6:0], 7'd0};
         3'd2:    shifted = {11'd0, b[6:0], 14'd0};
         3'd3:    shifted = {4'd0, b[6:0], 21'd0};
         3'd4:    shifted = {b[3:0], 28'd0};
         default: shifted = '0;
      endcase
   end

   assign acc_new   = eff_acc | shifted;
   assign units_dec = eff_units - 32'd1;
   assign part_new  = {eff_partial[9:0], b[5:0]};
   assign cont_dec  = eff_cont - 2'd1;
   assign overlong  = (eff_seq == 2'd1 && part_new < MIN_TWO_BYTE && part_new != 16'd0) ||
                      (eff_seq == 2'd2 && part_new < MIN_THREE_BYTE);

   // next state and result for one byte
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      units_in   = units_ff;
      partial_in = partial_ff;
      cont_in    = cont_ff;
      seq_in     = seq_ff;
      res_valid  = 1'b0;
      res        = '0;
      if (fire) begin
         phase_in   = eff_phase;
         pos_in     = eff_pos;
         acc_in     = eff_acc;
         units_in   = eff_units;
         partial_in = eff_partial;
         cont_in    = eff_cont;
         seq_in     = eff_seq;
         unique case (eff_phase)
            PH_PREFIX: begin
               if (eff_pos >= PREFIX_LAST_POS && b[7:4] != 4'd0) begin
                  phase_in       = PH_DONE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
                  res.last       = 1'b1;
               end else if (!b[7] || eff_pos >= PREFIX_LAST_POS) begin
                  acc_in = acc_new;
                  if (acc_new > max_units) begin
                     phase_in       = PH_DONE;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_LIMIT;
                     res.last       = 1'b1;
                  end else begin
                     units_in = acc_new;
                     phase_in = (acc_new == 32'd0) ? PH_TERM : PH_LEAD;
                  end
               end else begin
                  acc_in = acc_new;
                  pos_in = eff_pos + 3'd1;
               end
            end
            PH_LEAD: begin
               if (b == 8'd0) begin
                  phase_in       = PH_DONE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
                  res.last       = 1'b1;
               end else if (!b[7]) begin
                  units_in      = units_dec;
                  phase_in      = (units_dec == 32'd0) ? PH_TERM : PH_LEAD;
                  res_valid     = 1'b1;
                  res.kind      = KIND_UNIT;
                  res.code_unit = {8'd0, b};
               end else if (b[7:5] == 3'b110) begin
                  partial_in = {11'd0, b[4:0]};
                  cont_in    = 2'd1;
                  seq_in     = 2'd1;
                  phase_in   = PH_CONT;
               end else if (b[7:4] == 4'b1110) begin
                  partial_in = {12'd0, b[3:0]};
                  cont_in    = 2'd2;
                  seq_in     = 2'd2;
                  phase_in   = PH_CONT;
               end else begin
                  phase_in       = PH_DONE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
                  res.last       = 1'b1;
               end
            end
            PH_CONT: begin
               if (b[7:6] != 2'b10) begin
                  phase_in       = PH_DONE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
                  res.last       = 1'b1;
               end else begin
                  partial_in = part_new;
                  cont_in    = cont_dec;
                  if (cont_dec != 2'd0) begin
                     phase_in = PH_CONT;
                  end else if (overlong) begin
                     phase_in       = PH_DONE;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_MALFORMED;
                     res.last       = 1'b1;
                  end else begin
                     units_in      = units_dec;
                     phase_in      = (units_dec == 32'd0) ? PH_TERM : PH_LEAD;
                     res_valid     = 1'b1;
                     res.kind      = KIND_UNIT;
                     res.code_unit = part_new;
                  end
               end
            end
            PH_TERM: begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.last  = 1'b1;
               if (b != 8'd0) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MALFORMED;
               end else begin
                  res.kind           = KIND_COMPLETE;
                  res.declared_count = eff_acc;
               end
            end
            default: begin
               // idle or finished: byte without a record is dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         acc_ff     <= '0;
         units_ff   <= '0;
         partial_ff <= '0;
         cont_ff    <= '0;
         seq_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         units_ff   <= units_in;
         partial_ff <= partial_in;
         cont_ff    <= cont_in;
         seq_ff     <= seq_in;
      end
   end

endmodule

[hw/rtl/mutf8_out_stage.sv]
// mutf8_out_stage: result register toward the rsp channel
// depends on mutf8_pkg
module mutf8_out_stage
   import mutf8_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type res,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // slot is free when empty or being drained this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[hw/rtl/mutf8_string_data_decoder.sv]
// Modified UTF-8 string record decoder, one byte per req transfer.
// An accepted byte waits in the input register, passes the decode logic and is
// registered in the result register, from which it shows on rsp.
// Throughput: one byte per cycle; a byte advances when the result register is free.
// Reset (synchronous): decoder idle, pipeline empty, max_units all ones.
// Depends on mutf8_pkg, mutf8_in_stage, mutf8_core, mutf8_out_stage.
module mutf8_string_data_decoder
   import mutf8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] max_units_ff, max_units_in;
   logic        item_valid;
   req_type     item;
   logic        free;
   logic        advance;
   logic        res_valid;
   rsp_type     res;

   // configuration register
   assign csr_ready    = 1'b1;
   assign max_units_in = (csr_valid && csr_ready) ? csr_data : max_units_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= '1;
      end else begin
         max_units_ff <= max_units_in;
      end
   end

   // a byte moves from the input register into decode when the result slot is free
   assign advance = item_valid && free;

   mutf8_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mutf8_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .max_units (max_units_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   mutf8_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/mutf8_checker.sv]
// mutf8_checker: port-level assertions for the decoder, bound to the top level
// depends on mutf8_pkg and mutf8_string_data_decoder
module mutf8_checker
   import mutf8_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // no result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a code unit carries no error, no count and no last flag
   a_unit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_UNIT |->
         rsp_data.error_code == ERR_NONE && rsp_data.declared_count == 32'd0 &&
         !rsp_data.last)
      else $error("code unit result with stray fields");

   // last goes with completion or error only
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         rsp_data.kind == KIND_COMPLETE || rsp_data.kind == KIND_ERROR)
      else $error("last on a code unit");

   // an error names a real code and no unit
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ERROR |->
         rsp_data.code_unit == 16'd0 && rsp_data.last &&
         (rsp_data.error_code == ERR_MALFORMED || rsp_data.error_code == ERR_LIMIT))
      else $error("malformed error result");

endmodule

bind mutf8_string_data_decoder mutf8_checker u_mutf8_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
